[sv/peak_concurrent_interval_tracker_defines.svh]
// assertion macros for the checker file of the interval tracker
// depends on nothing; included by bare file name
`ifndef PEAK_CONCURRENT_INTERVAL_TRACKER_DEFINES_SVH
`define PEAK_CONCURRENT_INTERVAL_TRACKER_DEFINES_SVH

// concurrent assertion, disabled while reset is low
`define PCIT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that also holds during reset
`define PCIT_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/pcit_pkg.sv]
// types, sizes and sequencer states of the interval tracker
// depends on nothing; used by the top level and the checker
`default_nettype none

package pcit_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned OCC_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned END_W      = TIME_W + 1;
  localparam int unsigned COUNT_W    = 11;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] active_count;
    logic [COUNT_W-1:0] peak_count;
    logic               overflow;
  } result_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_POP_LAST,
    ST_SD_LEFT,
    ST_SD_RIGHT,
    ST_SD_CMP,
    ST_PUSH,
    ST_SU_RD,
    ST_SU_CMP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[sv/pcit_ram.sv]
// generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module pcit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/peak_concurrent_interval_tracker.sv]
// interval tracker top level: min-heap of end times in a ram, one sequencer
// depends on pcit_pkg and pcit_ram
//
//   channel   dir  handshake              word
//   item      in   start & !busy          item_i  (start_time, duration)
//   result    out  valid_o, one cycle     result_o (active_count, peak_count, overflow)
//
// work: an item removes every expired end time at the root, each removal
//   sifting the heap down, then the new end time sifts up (each sift at most
//   log2 of the heap depth levels); every heap step waits on the single
//   registered read port of the ram
// the result strobe is registered out of the done state and shows while busy
//   is already low, so the next word can be taken in that same cycle
// reset empties the heap by clearing the occupancy, clears the peak and the
//   strobe; the ram itself is never cleared and only live entries are read
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module peak_concurrent_interval_tracker (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire pcit_pkg::in_item_t      item_i,
  output logic                         valid_o,
  output pcit_pkg::result_item_t       result_o
);

  import pcit_pkg::*;

  state_e             state_q, state_d;
  logic [TIME_W-1:0]  start_q, start_d;   // start time of the word in flight
  logic [END_W-1:0]   end_q, end_d;       // its end time, 33 bits
  logic [END_W-1:0]   hole_q, hole_d;     // value carried by the sift hole
  logic [END_W-1:0]   lval_q, lval_d;     // left child during sift down
  logic               rvld_q, rvld_d;     // right child exists
  logic [ADDR_W-1:0]  pos_q, pos_d;       // hole position
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [OCC_W-1:0]   peak_q, peak_d;
  logic               ovf_q, ovf_d;
  logic               valid_q, valid_d;
  result_item_t       res_q, res_d;

  // heap ram port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [END_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [END_W-1:0]   ram_rdata;

  // child indexes wide enough to compare against the occupancy, and the parent index
  logic [ADDR_W+1:0]  left_idx;
  logic [ADDR_W+1:0]  right_idx;
  logic [ADDR_W+1:0]  occ_ext;
  logic [ADDR_W-1:0]  parent_idx;

  // sift-down selection among hole, left and right
  logic               take_left;
  logic               take_right;
  logic [END_W-1:0]   best_val;

  assign left_idx   = {1'b0, pos_q, 1'b1};
  assign right_idx  = left_idx + (ADDR_W+2)'(1);
  assign occ_ext    = (ADDR_W+2)'(occ_q);
  assign parent_idx = (pos_q - ADDR_W'(1)) >> 1;

  assign take_left  = lval_q < hole_q;
  assign take_right = rvld_q && (ram_rdata < (take_left ? lval_q : hole_q));
  assign best_val   = take_right ? ram_rdata : lval_q;

  pcit_ram #(
    .WIDTH (END_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      peak_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      peak_q  <= peak_d;
      valid_q <= valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    hole_q  <= hole_d;
    lval_q  <= lval_d;
    rvld_q  <= rvld_d;
    pos_q   <= pos_d;
    ovf_q   <= ovf_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    start_d   = start_q;
    end_d     = end_q;
    hole_d    = hole_q;
    lval_d    = lval_q;
    rvld_d    = rvld_q;
    pos_d     = pos_q;
    occ_d     = occ_q;
    peak_d    = peak_q;
    ovf_d     = ovf_q;
    res_d     = res_q;
    valid_d   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = hole_q;
    ram_raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          start_d = item_i.start_time;
          end_d   = {1'b0, item_i.start_time} + {1'b0, item_i.duration};
          ovf_d   = 1'b0;
          state_d = ST_CHK_RD;
        end
      end

      // look at the root: remove it if it ended at or before the new start
      ST_CHK_RD: begin
        if (occ_q == '0) begin
          state_d = ST_PUSH;
        end else begin
          ram_raddr = '0;
          state_d   = ST_CHK_CMP;
        end
      end

      ST_CHK_CMP: begin
        if (ram_rdata <= {1'b0, start_q}) begin
          occ_d = occ_q - OCC_W'(1);
          if (occ_q == OCC_W'(1)) begin
            state_d = ST_PUSH;
          end else begin
            ram_raddr = ADDR_W'(occ_q - OCC_W'(1));
            state_d   = ST_POP_LAST;
          end
        end else begin
          state_d = ST_PUSH;
        end
      end

      // last entry moves into the root hole
      ST_POP_LAST: begin
        hole_d  = ram_rdata;
        pos_d   = '0;
        state_d = ST_SD_LEFT;
      end

      ST_SD_LEFT: begin
        if (left_idx >= occ_ext) begin
          ram_we  = 1'b1;
          state_d = ST_CHK_RD;
        end else begin
          ram_raddr = ADDR_W'(left_idx);
          state_d   = ST_SD_RIGHT;
        end
      end

      ST_SD_RIGHT: begin
        lval_d    = ram_rdata;
        rvld_d    = right_idx < occ_ext;
        ram_raddr = ADDR_W'(right_idx);
        state_d   = ST_SD_CMP;
      end

      ST_SD_CMP: begin
        ram_we = 1'b1;
        if (take_left || take_right) begin
          ram_wdata = best_val;
          pos_d     = take_right ? ADDR_W'(right_idx) : ADDR_W'(left_idx);
          state_d   = ST_SD_LEFT;
        end else begin
          state_d = ST_CHK_RD;
        end
      end

      // append the new end time, or drop it when the heap is full
      ST_PUSH: begin
        if (occ_q >= OCC_W'(HEAP_DEPTH)) begin
          ovf_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          pos_d   = ADDR_W'(occ_q);
          hole_d  = end_q;
          occ_d   = occ_q + OCC_W'(1);
          state_d = ST_SU_RD;
        end
      end

      ST_SU_RD: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ram_raddr = parent_idx;
          state_d   = ST_SU_CMP;
        end
      end

      ST_SU_CMP: begin
        ram_we = 1'b1;
        if (hole_q < ram_rdata) begin
          ram_wdata = ram_rdata;
          pos_d     = parent_idx;
          state_d   = ST_SU_RD;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        peak_d             = (occ_q > peak_q) ? occ_q : peak_q;
        res_d.active_count = COUNT_W'(occ_q);
        res_d.peak_count   = COUNT_W'(peak_d);
        res_d.overflow     = ovf_q;
        valid_d            = 1'b1;
        state_d            = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

[sv/pcit_checker.sv]
// port-level checker for the interval tracker, bound to the top level
// depends on pcit_pkg and peak_concurrent_interval_tracker_defines.svh
`default_nettype none

`include "peak_concurrent_interval_tracker_defines.svh"

module pcit_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   start,
  input wire logic                   busy,
  input wire pcit_pkg::in_item_t     item_i,
  input wire logic                   valid_o,
  input wire pcit_pkg::result_item_t result_o
);

  import pcit_pkg::*;

  logic in_word_seen;
  assign in_word_seen = (item_i.start_time == item_i.start_time);

  // a taken word keeps the block busy on the next cycle
  `PCIT_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy && in_word_seen) |=> busy, "busy not raised after accept")

  // results only show up once the sequencer is done
  `PCIT_ASSERT(a_valid_idle, clk_i, rst_ni, valid_o |-> !busy, "result while busy")

  // a result strobe lasts a single cycle
  `PCIT_ASSERT(a_valid_pulse, clk_i, rst_ni, valid_o |=> !valid_o, "result strobe longer than one cycle")

  // the running peak never trails the active count
  `PCIT_ASSERT(a_peak_ge, clk_i, rst_ni, valid_o |-> (result_o.peak_count >= result_o.active_count), "peak below active count")

  // a dropped interval means the heap is at its peak fill
  `PCIT_ASSERT(a_ovf_full, clk_i, rst_ni, (valid_o && result_o.overflow) |-> (result_o.active_count == result_o.peak_count), "overflow without full heap")

endmodule

bind peak_concurrent_interval_tracker pcit_checker u_pcit_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .valid_o  (valid_o),
  .result_o (result_o)
);

`default_nettype wire

[test/tb_peak_concurrent_interval_tracker.sv]
// self-checking bench for peak_concurrent_interval_tracker: directed corners, random
// interval streams, a full-heap overflow phase and a mass expiry
// depends on pcit_pkg and the tracker rtl; reads nothing at run time
`timescale 1ns / 100ps

// predicts active and peak counts from a sorted list of live end times
class concurrency_board;
  logic [pcit_pkg::END_W-1:0] live_ends[$];   // ascending end times
  int unsigned                peak;
  pcit_pkg::result_item_t     pending_counts[$];
  int unsigned                errors;
  int unsigned                checked;
  int unsigned                dropped;

  function new();
    peak    = 0;
    errors  = 0;
    checked = 0;
    dropped = 0;
  endfunction

  function int unsigned live_count();
    return live_ends.size();
  endfunction

  function int unsigned outstanding();
    return pending_counts.size();
  endfunction

  // accepted word: expire, insert, note the counts the block must report
  function void take_interval(pcit_pkg::in_item_t it);
    logic [pcit_pkg::END_W-1:0] fin;
    pcit_pkg::result_item_t     want;
    int unsigned                slot;
    int unsigned                fill;
    fin = {1'b0, it.start_time} + {1'b0, it.duration};
    // every end at or before the new start leaves, order of arrival aside
    while (live_ends.size() != 0 && live_ends[0] <= {1'b0, it.start_time})
      live_ends.delete(0);
    want.overflow = (live_ends.size() >= pcit_pkg::HEAP_DEPTH);
    if (!want.overflow) begin
      slot = 0;
      while (slot < live_ends.size() && live_ends[slot] <= fin) slot++;
      live_ends.insert(slot, fin);
    end else begin
      dropped++;
    end
    if (live_ends.size() > peak) peak = live_ends.size();
    fill = live_ends.size();
    want.active_count = fill[pcit_pkg::COUNT_W-1:0];
    want.peak_count   = peak[pcit_pkg::COUNT_W-1:0];
    pending_counts.push_back(want);
  endfunction

  function void compare_field(string field, logic [pcit_pkg::COUNT_W-1:0] want,
                              logic [pcit_pkg::COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_counts(pcit_pkg::result_item_t got);
    pcit_pkg::result_item_t want;
    if (pending_counts.size() == 0) begin
      $display("%0t: unexpected result word, actual active %0d peak %0d overflow %0b",
               $time, got.active_count, got.peak_count, got.overflow);
      errors++;
      return;
    end
    want = pending_counts.pop_front();
    checked++;
    compare_field("active_count", want.active_count, got.active_count);
    compare_field("peak_count", want.peak_count, got.peak_count);
    compare_field("overflow", {{(pcit_pkg::COUNT_W-1){1'b0}}, want.overflow},
                  {{(pcit_pkg::COUNT_W-1){1'b0}}, got.overflow});
  endfunction
endclass

module tb_peak_concurrent_interval_tracker;
  import pcit_pkg::*;

  // the slowest word removes a full heap of 1024 entries one pop at a time, so
  // a stretch without any handshake that reaches STALL_LIMIT means the block hung
  localparam int unsigned STALL_LIMIT = 200000;

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start  = 1'b0;
  logic         busy;
  in_item_t     item_i = '0;
  logic         valid_o;
  result_item_t result_o;

  concurrency_board board = new();

  logic [TIME_W-1:0] timeline = '0;   // current start time of well-formed streams
  int unsigned       idle_pct = 0;    // chance of a sender gap before a word
  int unsigned       sent     = 0;
  int unsigned       stall_cycles = 0;

  peak_concurrent_interval_tracker i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // start stays high across back-to-back words; it only drops for a gap,
  // so it never sees two assignments in one step
  task automatic send_interval(input in_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    // values read here are the ones the edge sampled
    while (busy) @(posedge clk_i);
    board.take_interval(it);
    sent++;
  endtask

  // mostly nondecreasing starts with short lives; some long or full-width
  // durations, and some noise with random or slightly earlier starts
  function automatic in_item_t next_random();
    in_item_t it;
    if ($urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 49) == 0) timeline += $urandom_range(1, 1 << 18);
      else timeline += $urandom_range(0, 8);
      it.start_time = timeline;
      case ($urandom_range(0, 19))
        0: begin
          it.duration = $urandom();
        end
        1, 2, 3: begin
          it.duration = $urandom_range(0, 2000);
        end
        default: begin
          it.duration = $urandom_range(0, 64);
        end
      endcase
    end else begin
      it.start_time = $urandom_range(0, 1) ? $urandom() : timeline - $urandom_range(0, 40);
      it.duration   = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 64);
    end
    return it;
  endfunction

  // result strobe cannot be held off: check it at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) board.check_counts(result_o);
  end

  // watchdog on cycles without any accepted word in either direction
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, board.outstanding());
      $display("FAIL peak_concurrent_interval_tracker");
      $finish;
    end
  end

  // corners: {start_time, duration}
  logic [63:0] corner [15] = '{
    {32'h0000_0000, 32'h0000_0000},   // zero duration, active for its own word
    {32'h0000_0000, 32'h0000_0000},   // same start removes the zero-length one
    {32'h0000_0005, 32'h0000_000a},
    {32'h0000_0005, 32'h0000_0003},
    {32'h0000_0008, 32'h0000_0064},   // removes an end equal to its start
    {32'h0000_0007, 32'h0000_0001},   // earlier start than the last word
    {32'h0000_000f, 32'h0000_0000},   // removes two ends at once
    {32'h7fff_ffff, 32'h8000_0001},   // end lands exactly on bit 32
    {32'hffff_ffff, 32'hffff_ffff},   // largest end, carries into bit 32
    {32'hffff_ffff, 32'h0000_0000},
    {32'hffff_ffff, 32'h0000_0001},   // largest start removes the line above
    {32'h0000_0000, 32'hffff_ffff},   // far out of order
    {32'haaaa_aaaa, 32'h5555_5555},
    {32'h5555_5555, 32'haaaa_aaaa},
    {32'h0000_0001, 32'h0000_0001}
  };

  initial begin
    in_item_t    it;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners, back to back
    foreach (corner[k]) send_interval(in_item_t'(corner[k]));

    // random streams, gap density picked anew every 64 words
    for (n = 0; n < 150; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      send_interval(next_random());
    end

    // fill the heap with one shared start until it is full
    timeline += 1000;
    idle_pct = 10;
    while (board.live_count() < HEAP_DEPTH) begin
      it.start_time = timeline;
      it.duration   = $urandom_range(1, 400);
      send_interval(it);
    end
    // full and nothing expires: each of these words is dropped
    repeat (3) begin
      it.start_time = timeline;
      it.duration   = $urandom_range(0, 400);
      send_interval(it);
    end
    // expiry frees room on the full heap, so no drop
    it.start_time = timeline + 200;
    it.duration   = 5;
    send_interval(it);
    // mass expiry of everything from the fill
    timeline += 1000;
    it.start_time = timeline;
    it.duration   = 3;
    send_interval(it);

    // closing stretch with no sender gaps
    idle_pct = 0;
    for (n = 0; n < 60; n++) send_interval(next_random());
    start <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    // a stray late strobe in this stretch would be flagged as unexpected
    repeat (64) @(posedge clk_i);

    $display("sent %0d intervals, checked %0d results, %0d dropped on a full heap",
             sent, board.checked, board.dropped);
    $display("peak concurrency reached %0d of %0d heap entries", board.peak, HEAP_DEPTH);
    if (board.errors == 0) begin
      $display("PASS peak_concurrent_interval_tracker");
    end else begin
      $display("FAIL peak_concurrent_interval_tracker");
    end
    $finish;
  end

endmodule
